/* rtl/core/bpk_pkg.sv */
// Package for the MSB-first bit packer: shared types, queue sizes and codes.
// Used by bpk_front, bpk_back, bpk_result_queue and msb_first_bit_packer.
// Depends on nothing.
package bpk_pkg;

    // byte geometry
    localparam int BYTE_W    = 8;
    localparam int BITCNT_W  = 4;   // holds 0..8
    localparam int PEND_W    = 3;   // pending bit count, 0..7
    localparam int SUM_W     = 5;   // start_bit + bit_count, 0..30

    // queue sizes (powers of two, pointers wrap naturally)
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // number of results the back end may write in one cycle
    localparam int RES_PER_CMD = 2;

    localparam logic [BITCNT_W-1:0] FULL_BYTE_BITS = 4'd8;
    localparam logic [BYTE_W-1:0]   BYTE_MASK      = 8'hFF;

    // classified request passed from front to back
    typedef struct packed {
        logic                range_err;
        logic [BYTE_W-1:0]   field;      // right-aligned field bits
        logic [BITCNT_W-1:0] count;
        logic                eos;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [BITCNT_W-1:0] valid_bits;
        logic                stream_end;
        logic                range_error;
    } result_t;

    // handshake bundle from back end to result queue
    typedef struct packed {
        logic [1:0] push_cnt;   // 0, 1 or 2 results this cycle
        result_t    res0;
        result_t    res1;
    } res_push_t;

endpackage

/* rtl/core/msb_first_bit_packer.sv */
// MSB-first bit packer, top level. An accepted request waits in the command queue; the back
// end merges it and writes its results to the result queue, which drives the ports. One
// request per cycle while the result queue has room; a request yielding two results takes
// two pops of the single-pop queue. Reset (rst_n, asynchronous, active low) empties both queues
// and clears the pending partial byte. Depends on bpk_pkg, bpk_front, bpk_back, bpk_result_queue.
module msb_first_bit_packer
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [bpk_pkg::BYTE_W-1:0]     src_byte,
    input  logic [bpk_pkg::BITCNT_W-1:0]   start_bit,
    input  logic [bpk_pkg::BITCNT_W-1:0]   bit_count,
    input  logic                           end_of_stream,
    output logic                           empty,
    input  logic                           pop,
    output logic [bpk_pkg::BYTE_W-1:0]     out_byte,
    output logic [bpk_pkg::BITCNT_W-1:0]   valid_bits,
    output logic                           stream_end,
    output logic                           range_error
);

    logic                  cmd_valid;
    logic                  cmd_take;
    bpk_pkg::cmd_t         cmd;
    logic                  res_room;
    bpk_pkg::res_push_t    res_push;
    bpk_pkg::result_t      head;

    // classify requests and queue them
    bpk_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .src_byte      (src_byte),
        .start_bit     (start_bit),
        .bit_count     (bit_count),
        .end_of_stream (end_of_stream),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_take      (cmd_take)
    );

    // pack into bytes
    bpk_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_room  (res_room),
        .res_push  (res_push)
    );

    // buffer results towards the consumer
    bpk_result_queue u_res_q
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_room (res_room),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    assign out_byte    = head.out_byte;
    assign valid_bits  = head.valid_bits;
    assign stream_end  = head.stream_end;
    assign range_error = head.range_error;

endmodule

/* rtl/core/bpk_front.sv */
// Front end of the bit packer: range check and field extraction, then a
// short command queue towards the back end. Depends on bpk_pkg.
module bpk_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [bpk_pkg::BYTE_W-1:0]     src_byte,
    input  logic [bpk_pkg::BITCNT_W-1:0]   start_bit,
    input  logic [bpk_pkg::BITCNT_W-1:0]   bit_count,
    input  logic                           end_of_stream,
    output logic                           cmd_valid,
    output bpk_pkg::cmd_t                  cmd,
    input  logic                           cmd_take
);

    bpk_pkg::cmd_t                     cmd_mem_reg [bpk_pkg::CMD_DEPTH];
    logic [bpk_pkg::CMD_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bpk_pkg::CMD_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bpk_pkg::CMD_CNT_W-1:0]     cnt_reg, cnt_next;

    logic [bpk_pkg::SUM_W-1:0]         bit_sum;
    logic [bpk_pkg::BITCNT_W-1:0]      shamt;
    logic [bpk_pkg::BYTE_W:0]          mask_wide;
    bpk_pkg::cmd_t                     new_cmd;
    logic                              do_push;
    logic                              do_pop;

    // classify the request: out-of-byte field or right-aligned field bits
    always_comb
    begin
        bit_sum   = bpk_pkg::SUM_W'(start_bit) + bpk_pkg::SUM_W'(bit_count);
        shamt     = bpk_pkg::BITCNT_W'(bpk_pkg::SUM_W'(bpk_pkg::BYTE_W) - bit_sum);
        mask_wide = ((bpk_pkg::BYTE_W+1)'(1) << bit_count) - (bpk_pkg::BYTE_W+1)'(1);
        new_cmd.range_err = (bit_sum > bpk_pkg::SUM_W'(bpk_pkg::BYTE_W));
        new_cmd.count     = bit_count;
        new_cmd.eos       = end_of_stream;
        if (new_cmd.range_err)
        begin
            new_cmd.field = '0;
        end
        else
        begin
            new_cmd.field = (src_byte >> shamt) & mask_wide[bpk_pkg::BYTE_W-1:0];
        end
    end

    // queue control
    assign full      = (cnt_reg == bpk_pkg::CMD_CNT_W'(bpk_pkg::CMD_DEPTH));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = cmd_mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + bpk_pkg::CMD_CNT_W'(do_push)
                              - bpk_pkg::CMD_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // command storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            cmd_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

/* rtl/core/bpk_back.sv */
// Back end of the bit packer: holds the pending partial byte, merges each
// command into it and produces up to two results. Depends on bpk_pkg.
module bpk_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  bpk_pkg::cmd_t        cmd,
    output logic                 cmd_take,
    input  logic                 res_room,
    output bpk_pkg::res_push_t   res_push
);

    logic [bpk_pkg::BYTE_W-1:0]    pend_byte_reg, pend_byte_next;
    logic [bpk_pkg::PEND_W-1:0]    pend_bits_reg, pend_bits_next;

    logic [bpk_pkg::BITCNT_W-1:0]  total;
    logic [bpk_pkg::SUM_W-1:0]     place;
    logic [2*bpk_pkg::BYTE_W-1:0]  acc;
    logic [bpk_pkg::PEND_W-1:0]    rem;
    logic                          full_out;
    logic                          flush_out;
    logic [bpk_pkg::BYTE_W-1:0]    merged;
    bpk_pkg::result_t              full_res;
    bpk_pkg::result_t              flush_res;
    bpk_pkg::result_t              err_res;

    assign cmd_take = cmd_valid && res_room;

    // merge the field below the pending bits in a 16-bit window
    always_comb
    begin
        total = bpk_pkg::BITCNT_W'(pend_bits_reg) + cmd.count;
        place = bpk_pkg::SUM_W'(2*bpk_pkg::BYTE_W) - bpk_pkg::SUM_W'(total);
        acc   = {pend_byte_reg, bpk_pkg::BYTE_W'(0)}
              | ((2*bpk_pkg::BYTE_W)'(cmd.field) << place);
        full_out  = (total >= bpk_pkg::FULL_BYTE_BITS);
        rem       = total[bpk_pkg::PEND_W-1:0];
        merged    = full_out ? acc[bpk_pkg::BYTE_W-1:0]
                             : acc[2*bpk_pkg::BYTE_W-1:bpk_pkg::BYTE_W];
        flush_out = cmd.eos && (rem != '0);
    end

    // candidate results
    always_comb
    begin
        full_res.out_byte    = acc[2*bpk_pkg::BYTE_W-1:bpk_pkg::BYTE_W];
        full_res.valid_bits  = bpk_pkg::FULL_BYTE_BITS;
        full_res.stream_end  = cmd.eos && (rem == '0);
        full_res.range_error = 1'b0;

        flush_res.out_byte    = merged;
        flush_res.valid_bits  = bpk_pkg::BITCNT_W'(rem);
        flush_res.stream_end  = 1'b1;
        flush_res.range_error = 1'b0;

        err_res.out_byte    = '0;
        err_res.valid_bits  = '0;
        err_res.stream_end  = 1'b0;
        err_res.range_error = 1'b1;
    end

    // results in order, and next pending state
    always_comb
    begin
        res_push.push_cnt = 2'd0;
        res_push.res0     = full_res;
        res_push.res1     = flush_res;
        pend_byte_next    = pend_byte_reg;
        pend_bits_next    = pend_bits_reg;
        if (cmd_take)
        begin
            if (cmd.range_err)
            begin
                res_push.push_cnt = 2'd1;
                res_push.res0     = err_res;
            end
            else
            begin
                if (flush_out)
                begin
                    pend_byte_next = '0;
                    pend_bits_next = '0;
                end
                else
                begin
                    pend_byte_next = merged;
                    pend_bits_next = rem;
                end
                if (full_out && flush_out)
                begin
                    res_push.push_cnt = 2'd2;
                end
                else if (full_out)
                begin
                    res_push.push_cnt = 2'd1;
                end
                else if (flush_out)
                begin
                    res_push.push_cnt = 2'd1;
                    res_push.res0     = flush_res;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_byte_reg <= '0;
            pend_bits_reg <= '0;
        end
        else
        begin
            pend_byte_reg <= pend_byte_next;
            pend_bits_reg <= pend_bits_next;
        end
    end

endmodule

/* rtl/core/bpk_result_queue.sv */
// Result queue of the bit packer: takes up to two results a cycle from the
// back end, hands out one a cycle. Depends on bpk_pkg.
module bpk_result_queue
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpk_pkg::res_push_t   res_push,
    output logic                 res_room,
    output logic                 empty,
    input  logic                 pop,
    output bpk_pkg::result_t     head
);

    bpk_pkg::result_t                  res_mem_reg [bpk_pkg::RES_DEPTH];
    logic [bpk_pkg::RES_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [bpk_pkg::RES_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [bpk_pkg::RES_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [bpk_pkg::RES_PTR_W-1:0]     wr_ptr_plus1;
    logic                              do_pop;

    // room for a worst-case command, judged on the current fill alone
    assign res_room = (cnt_reg <= bpk_pkg::RES_CNT_W'(bpk_pkg::RES_DEPTH
                                                      - bpk_pkg::RES_PER_CMD));
    assign empty    = (cnt_reg == '0);
    assign head     = res_mem_reg[rd_ptr_reg];
    assign do_pop   = pop && !empty;
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + bpk_pkg::RES_PTR_W'(res_push.push_cnt);
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + bpk_pkg::RES_CNT_W'(res_push.push_cnt)
                              - bpk_pkg::RES_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // result storage, first and second slot of this cycle's write
    always_ff @(posedge clk)
    begin
        if (res_push.push_cnt != 2'd0)
        begin
            res_mem_reg[wr_ptr_reg] <= res_push.res0;
        end
        if (res_push.push_cnt == 2'd2)
        begin
            res_mem_reg[wr_ptr_plus1] <= res_push.res1;
        end
    end

endmodule
